// ===== rtl/tea_block_cipher_core_defines.svh =====
// Assertion helpers for the checker file of the cipher core.
`ifndef TEA_BLOCK_CIPHER_CORE_DEFINES_SVH
`define TEA_BLOCK_CIPHER_CORE_DEFINES_SVH

// Checked at every rising edge of clk, ignored while reset is asserted.
`define TEA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tea core check failed");

// Checked at every rising edge of clk, reset included.
`define TEA_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("tea core check failed");

`endif

// ===== rtl/tea_pkg.sv =====
package tea_pkg;

    // Cipher constants.
    localparam logic [31:0] ROUND_DELTA = 32'h9e37_79b9;
    localparam int          MAX_ROUNDS  = 32;
    localparam int          STAGES      = 2 * MAX_ROUNDS;

    // Configuration port widths.
    localparam int          CFG_DATA_W  = 32;
    localparam int          CFG_INDEX_W = 3;
    localparam int          RCNT_W      = 6;
    // Wide enough for the raw count and for any round limit up to 64.
    localparam int          ROUND_CMP_W = RCNT_W + 1;
    localparam logic [ROUND_CMP_W-1:0] MAX_EFF = ROUND_CMP_W'(MAX_ROUNDS);

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_KEY0   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY1   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY2   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY3   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ROUNDS = 3'd4;

    // Register reset values.
    localparam logic [31:0]       KEY0_RST   = 32'h0403_0201;
    localparam logic [31:0]       KEY1_RST   = 32'h0807_0605;
    localparam logic [31:0]       KEY2_RST   = 32'h0C0B_0A09;
    localparam logic [31:0]       KEY3_RST   = 32'h100F_0E0D;
    localparam logic [RCNT_W-1:0] ROUNDS_RST = 6'd16;

    // Command codes.
    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    // Request word.
    typedef struct packed {
        logic        command;
        logic [31:0] block_word0;
        logic [31:0] block_word1;
    } tea_in_t;

    // Response word.
    typedef struct packed {
        logic [31:0] result_word0;
        logic [31:0] result_word1;
    } tea_out_t;

    // Contents of one pipeline stage.
    typedef struct packed {
        logic        command;
        logic [31:0] w0;
        logic [31:0] w1;
    } tea_stage_t;

    // TEA mixing function for one half round.
    function automatic logic [31:0] tea_mix(
        input logic [31:0] v,
        input logic [31:0] s,
        input logic [31:0] ka,
        input logic [31:0] kb
    );
        return ((v << 4) + ka) ^ (v + s) ^ ((v >> 5) + kb);
    endfunction

endpackage

// ===== rtl/tea_block_cipher_core.sv =====
// Channel  Direction  Handshake            Word
// req      in         req_valid/req_stall  tea_in_t  (command, block words)
// rsp      out        rsp_valid/rsp_stall  tea_out_t (result words)
// cfg      in         cfg_we               cfg_index, cfg_data
//
// One block enters per cycle unless a stalled response holds the pipeline; the
// input register takes each word at the accepting edge and one stage per half
// round follows (two stages per TEA cycle, 64 in all) to the response output.
// Reset (rst_n, asynchronous) empties the pipeline and loads the default key
// and a round count of 16.
// A stalled response freezes the whole pipeline and req_stall follows it.
module tea_block_cipher_core
    import tea_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  tea_in_t                req_word,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output tea_out_t               rsp_word,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [31:0]            key_reg [0:3];
    logic [RCNT_W-1:0]      round_count_reg;
    logic [ROUND_CMP_W-1:0] rounds_eff;

    logic                   valid_reg [0:STAGES];
    tea_stage_t             stage_reg [0:STAGES];
    tea_stage_t             stage_next [0:STAGES-1];
    logic                   advance;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg[0]      <= KEY0_RST;
            key_reg[1]      <= KEY1_RST;
            key_reg[2]      <= KEY2_RST;
            key_reg[3]      <= KEY3_RST;
            round_count_reg <= ROUNDS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEY0:   key_reg[0]      <= cfg_data;
                REG_KEY1:   key_reg[1]      <= cfg_data;
                REG_KEY2:   key_reg[2]      <= cfg_data;
                REG_KEY3:   key_reg[3]      <= cfg_data;
                REG_ROUNDS: round_count_reg <= cfg_data[RCNT_W-1:0];
                default:    ;
            endcase
        end
    end

    // The round count saturates at the maximum of 32 rounds.
    always_comb
    begin
        if ({1'b0, round_count_reg} > MAX_EFF)
            rounds_eff = MAX_EFF;
        else
            rounds_eff = {1'b0, round_count_reg};
    end

    // The pipeline moves unless a response sits stalled at the output.
    assign advance   = !(valid_reg[STAGES] && rsp_stall);
    assign req_stall = !advance;

    // One half round per stage. Encryption runs the rounds in order from the
    // first stage; decryption runs them in reverse so that the last round
    // sits at the last stage, and its unused rounds pass through at the front.
    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        localparam int          P       = k / 2;
        localparam bit          HALF_HI = (k % 2) == 1;
        localparam int          J_DEC   = MAX_ROUNDS - 1 - P;
        localparam logic [31:0] SUM_ENC = 32'(ROUND_DELTA * (P + 1));
        localparam logic [31:0] SUM_DEC = 32'(ROUND_DELTA * (J_DEC + 1));

        logic        enc;
        logic        active;
        logic        to_w0;
        logic [31:0] src;
        logic [31:0] tgt;
        logic [31:0] ka;
        logic [31:0] kb;
        logic [31:0] sum_k;
        logic [31:0] mix_k;
        logic [31:0] tgt_new;

        always_comb
        begin
            enc    = stage_reg[k].command == CMD_ENCRYPT;
            active = enc ? (ROUND_CMP_W'(P) < rounds_eff)
                         : (ROUND_CMP_W'(J_DEC) < rounds_eff);
            // The first half of an encrypt round and the second half of a
            // decrypt round both update the first word from the second.
            to_w0  = (enc != HALF_HI);
            src    = to_w0 ? stage_reg[k].w1 : stage_reg[k].w0;
            tgt    = to_w0 ? stage_reg[k].w0 : stage_reg[k].w1;
            ka     = to_w0 ? key_reg[0] : key_reg[2];
            kb     = to_w0 ? key_reg[1] : key_reg[3];
            sum_k  = enc ? SUM_ENC : SUM_DEC;
            mix_k  = tea_mix(src, sum_k, ka, kb);
            if (!active)
                tgt_new = tgt;
            else if (enc)
                tgt_new = tgt + mix_k;
            else
                tgt_new = tgt - mix_k;

            stage_next[k].command = stage_reg[k].command;
            stage_next[k].w0      = to_w0 ? tgt_new : stage_reg[k].w0;
            stage_next[k].w1      = to_w0 ? stage_reg[k].w1 : tgt_new;
        end
    end

    // Valid bits of the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= STAGES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (advance)
        begin
            valid_reg[0] <= req_valid;
            for (int i = 0; i < STAGES; i++)
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end
    end

    // Data of the pipeline.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stage_reg[0].command <= req_word.command;
            stage_reg[0].w0      <= req_word.block_word0;
            stage_reg[0].w1      <= req_word.block_word1;
            for (int i = 0; i < STAGES; i++)
            begin
                stage_reg[i+1] <= stage_next[i];
            end
        end
    end

    // Response word from the last stage.
    assign rsp_valid             = valid_reg[STAGES];
    assign rsp_word.result_word0 = stage_reg[STAGES].w0;
    assign rsp_word.result_word1 = stage_reg[STAGES].w1;

endmodule

// ===== rtl/tea_chk.sv =====
`include "tea_block_cipher_core_defines.svh"

module tea_chk
    import tea_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_stall,
    input logic     rsp_valid,
    input logic     rsp_stall,
    input tea_out_t rsp_word
);

    // A stalled response word stays in place.
    `TEA_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))

    // Requests are held off only while a response waits at the output.
    `TEA_ASSERT(a_req_stall_cause, req_stall |-> rsp_valid && rsp_stall)

    // A request offered while the output is free is taken at once.
    `TEA_ASSERT(a_req_taken, req_valid && !(rsp_valid && rsp_stall) |-> !req_stall)

    // The pipeline comes out of reset empty.
    `TEA_ASSERT_ALWAYS(a_reset_empty, !$past(rst_n) |-> !rsp_valid)

endmodule

bind tea_block_cipher_core tea_chk u_tea_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word)
);

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb
    import tea_pkg::*;
();

    // Clock, reset and block ports.
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_stall;
    tea_in_t                req_word = '0;
    logic                   rsp_valid;
    logic                   rsp_stall = 1'b0;
    tea_out_t               rsp_word;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Shadow copy of the cipher configuration.
    logic [31:0]       key_shadow [4];
    logic [RCNT_W-1:0] rounds_shadow;

    // Ciphertext or plaintext words still owed by the block, oldest first.
    tea_out_t expected_blocks [$];

    // Traffic shaping controls.
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int hold_request = 0;

    int mismatch_count = 0;
    int response_count = 0;
    tea_out_t want;

    tea_block_cipher_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Run limit, far above the slowest legal run.
    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    // One TEA half-round mixing term.
    function automatic logic [31:0] tea_feistel(
        input logic [31:0] v,
        input logic [31:0] s,
        input logic [31:0] ka,
        input logic [31:0] kb
    );
        return ((v << 4) + ka) ^ (v + s) ^ ((v >> 5) + kb);
    endfunction

    // Transforms one block under the shadow key and round count.
    function automatic tea_out_t tea_transform(input tea_in_t blk);
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] s;
        int          n;
        tea_out_t    res;
        n = int'(rounds_shadow);
        if (n > MAX_ROUNDS)
        begin
            n = MAX_ROUNDS;
        end
        y = blk.block_word0;
        z = blk.block_word1;
        s = '0;
        if (blk.command == CMD_ENCRYPT)
        begin
            for (int i = 0; i < n; i++)
            begin
                s = s + ROUND_DELTA;
                y = y + tea_feistel(z, s, key_shadow[0], key_shadow[1]);
                z = z + tea_feistel(y, s, key_shadow[2], key_shadow[3]);
            end
        end
        else
        begin
            // Decryption starts from the sum that encryption ends with.
            for (int i = 0; i < n; i++)
            begin
                s = s + ROUND_DELTA;
            end
            for (int i = 0; i < n; i++)
            begin
                z = z - tea_feistel(y, s, key_shadow[2], key_shadow[3]);
                y = y - tea_feistel(z, s, key_shadow[0], key_shadow[1]);
                s = s - ROUND_DELTA;
            end
        end
        res.result_word0 = y;
        res.result_word1 = z;
        return res;
    endfunction

    // Random data word, biased toward the all-zero and all-one extremes.
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic tea_in_t make_block(
        input logic        cmd,
        input logic [31:0] w0,
        input logic [31:0] w1
    );
        tea_in_t blk;
        blk.command     = cmd;
        blk.block_word0 = w0;
        blk.block_word1 = w1;
        return blk;
    endfunction

    // Writes one register and mirrors the write in the shadow copy.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx) inside
            REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_shadow[idx[1:0]] = data;
            REG_ROUNDS: rounds_shadow = data[RCNT_W-1:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_key(
        input logic [31:0] k0,
        input logic [31:0] k1,
        input logic [31:0] k2,
        input logic [31:0] k3
    );
        write_reg(REG_KEY0, k0);
        write_reg(REG_KEY1, k1);
        write_reg(REG_KEY2, k2);
        write_reg(REG_KEY3, k3);
    endtask

    // Offers one request word, waits for its acceptance, records its result.
    task automatic send_block(input tea_in_t blk);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_word  <= blk;
        do
            @(posedge clk);
        while (req_stall);
        expected_blocks.push_back(tea_transform(blk));
    endtask

    // Stops offering words and waits until every owed response has arrived.
    task automatic pause_until_drained();
        req_valid <= 1'b0;
        while (expected_blocks.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Default key and round count straight out of reset.
    task automatic test_default_key();
        send_block(make_block(CMD_ENCRYPT, 32'h0000_0000, 32'h0000_0000));
        send_block(make_block(CMD_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_block(make_block(CMD_DECRYPT, 32'h0000_0000, 32'h0000_0000));
        send_block(make_block(CMD_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_block(make_block(CMD_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF));
        send_block(make_block(CMD_DECRYPT, 32'hA5A5_A5A5, 32'h5A5A_5A5A));
        pause_until_drained();
    endtask

    // Zero rounds, one round, the maximum, and counts that saturate.
    task automatic test_round_limits();
        write_key(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        write_reg(REG_ROUNDS, 32'd0);
        send_block(make_block(CMD_ENCRYPT, 32'hDEAD_BEEF, 32'h0BAD_F00D));
        send_block(make_block(CMD_DECRYPT, 32'hDEAD_BEEF, 32'h0BAD_F00D));
        pause_until_drained();
        write_reg(REG_ROUNDS, 32'd1);
        send_block(make_block(CMD_ENCRYPT, 32'h1234_5678, 32'h9ABC_DEF0));
        send_block(make_block(CMD_DECRYPT, 32'h1234_5678, 32'h9ABC_DEF0));
        pause_until_drained();
        write_reg(REG_ROUNDS, MAX_ROUNDS);
        send_block(make_block(CMD_ENCRYPT, 32'h0000_0000, 32'h0000_0000));
        send_block(make_block(CMD_DECRYPT, 32'h41EA_3A0A, 32'h94BA_A940));
        pause_until_drained();
        // Counts above the limit run the maximum number of rounds.
        write_reg(REG_ROUNDS, MAX_ROUNDS + 1);
        send_block(make_block(CMD_ENCRYPT, 32'hFFFF_FFFF, 32'h0000_0000));
        send_block(make_block(CMD_DECRYPT, 32'h0000_0000, 32'hFFFF_FFFF));
        pause_until_drained();
        // Upper data bits beyond the round count field are dropped.
        write_reg(REG_ROUNDS, 32'hFFFF_FFFF);
        send_block(make_block(CMD_ENCRYPT, 32'hCAFE_BABE, 32'h8BAD_F00D));
        send_block(make_block(CMD_DECRYPT, 32'hCAFE_BABE, 32'h8BAD_F00D));
        pause_until_drained();
        write_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        write_reg(REG_ROUNDS, MAX_ROUNDS);
        send_block(make_block(CMD_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_block(make_block(CMD_DECRYPT, 32'h0000_0000, 32'h0000_0000));
        pause_until_drained();
    endtask

    // Writes to indexes past the last register must leave the setup alone.
    task automatic test_unused_index();
        write_key(32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210);
        write_reg(REG_ROUNDS, 32'd7);
        for (int idx = REG_ROUNDS + 1; idx < 2 ** CFG_INDEX_W; idx++)
        begin
            write_reg(CFG_INDEX_W'(idx), $urandom);
        end
        send_block(make_block(CMD_ENCRYPT, 32'h0F0F_0F0F, 32'hF0F0_F0F0));
        send_block(make_block(CMD_DECRYPT, 32'h0F0F_0F0F, 32'hF0F0_F0F0));
        pause_until_drained();
    endtask

    // Long response hold while requests keep coming, so the pipeline fills.
    task automatic test_full_pipeline();
        bit saved_tx;
        saved_tx = tx_idle_on;
        tx_idle_on = 1'b0;
        hold_request = 300;
        while (hold_request != 0)
        begin
            @(posedge clk);
        end
        for (int n = 0; n < 100; n++)
        begin
            send_block(make_block($urandom_range(0, 1) ? CMD_DECRYPT : CMD_ENCRYPT,
                                  rand_word(), rand_word()));
        end
        pause_until_drained();
        tx_idle_on = saved_tx;
    endtask

    // Fresh key and round count for one random phase.
    task automatic load_random_config();
        logic [31:0] rword;
        int          rcount;
        for (int i = 0; i < 4; i++)
        begin
            write_reg(REG_KEY0 + CFG_INDEX_W'(i), rand_word());
        end
        case ($urandom_range(0, 5))
            0: rcount = 0;
            1: rcount = 1;
            2: rcount = MAX_ROUNDS;
            3: rcount = $urandom_range(MAX_ROUNDS + 1, 2 ** RCNT_W - 1);
            default: rcount = $urandom_range(0, 2 ** RCNT_W - 1);
        endcase
        rword = $urandom;
        rword[RCNT_W-1:0] = RCNT_W'(rcount);
        write_reg(REG_ROUNDS, rword);
    endtask

    // Random blocks over several configurations and traffic shapes.
    task automatic test_random_traffic();
        for (int phase = 0; phase < 6; phase++)
        begin
            load_random_config();
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < 100; n++)
            begin
                send_block(make_block($urandom_range(0, 1) ? CMD_DECRYPT : CMD_ENCRYPT,
                                      rand_word(), rand_word()));
                if ($urandom_range(0, 39) == 0)
                begin
                    pause_until_drained();
                end
            end
            pause_until_drained();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Response side: random stalls per word, plus requested long holds.
    initial
    begin
        int k;
        int n;
        forever
        begin
            if (hold_request > 0)
            begin
                n = hold_request;
                hold_request = 0;
                rsp_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            else
            begin
                k = rx_idle_on ? $urandom_range(0, 8) : 0;
                if (k > 0)
                begin
                    rsp_stall <= 1'b1;
                    repeat (k) @(posedge clk);
                end
            end
            rsp_stall <= 1'b0;
            do
                @(posedge clk);
            while (!rsp_valid && hold_request == 0);
        end
    end

    // Compares each accepted response word with the oldest owed result.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            response_count++;
            if (expected_blocks.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("response %0d: unexpected word w0=%h w1=%h",
                             response_count, rsp_word.result_word0, rsp_word.result_word1);
                end
            end
            else
            begin
                want = expected_blocks.pop_front();
                if (rsp_word.result_word0 !== want.result_word0 ||
                    rsp_word.result_word1 !== want.result_word1)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("response %0d: expected w0=%h w1=%h, got w0=%h w1=%h",
                                 response_count, want.result_word0, want.result_word1,
                                 rsp_word.result_word0, rsp_word.result_word1);
                    end
                end
            end
        end
    end

    // Test sequence.
    initial
    begin
        key_shadow[0] = KEY0_RST;
        key_shadow[1] = KEY1_RST;
        key_shadow[2] = KEY2_RST;
        key_shadow[3] = KEY3_RST;
        rounds_shadow = ROUNDS_RST;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_key();
        test_round_limits();
        test_unused_index();
        test_full_pipeline();
        test_random_traffic();

        // Leave room for any stray response after the last owed one.
        pause_until_drained();
        repeat (80) @(posedge clk);
        if (mismatch_count == 0 && expected_blocks.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tea_pkg.sv
rtl/tea_block_cipher_core.sv
rtl/tea_chk.sv
verif/tb.sv
